// File: rtl/asbf_pkg.sv
// Shared types, codes and character helpers for the bigram-filtered string extractor.
package asbf_pkg;

    localparam int MAX_MIN_LENGTH = 32;
    localparam int MIN_LENGTH_W   = 6;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 32;
    localparam int KIND_W         = 2;
    localparam int DATA_W         = 32;
    localparam int PADDR_W        = 2;

    localparam logic [MIN_LENGTH_W-1:0] MIN_LENGTH_RESET = 6'd4;
    localparam logic [PADDR_W-1:0]      ADDR_MIN_LENGTH  = 2'd0;

    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_CLEAR_RUN = 2'd1;
    localparam logic [1:0] EV_APPEND    = 2'd2;
    localparam logic [1:0] EV_EXTEND    = 2'd3;

    localparam logic [1:0] OUT_BYTE   = 2'd0;
    localparam logic [1:0] OUT_PREFIX = 2'd1;
    localparam logic [1:0] OUT_END    = 2'd2;
    localparam logic [1:0] OUT_DONE   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  char_out;
        logic [COUNT_W-1:0] string_count;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic [1:0] eval_act;
        logic       k_clear;
        logic       k_inc;
        logic       rd_prefix;
        logic       out_load;
        logic [1:0] out_sel;
        logic       out_last;
        logic       start_string;
        logic       end_string;
        logic       clear_buffer;
    } cmd_t;

    typedef struct packed {
        logic in_string;
        logic alnum;
        logic forbid;
        logic run_nonzero;
        logic reach_thr;
        logic last;
        logic k_final;
    } status_t;

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
               (c >= 8'd48 && c <= 8'd57);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic bigram_bad(input logic [BYTE_W-1:0] a,
                                        input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic              bad;
        x = fold_case(a);
        y = fold_case(b);
        case (x)
            "b": bad = y inside {"k", "q", "x"};
            "c": bad = y inside {"b", "f", "g", "j", "p", "v", "w", "x"};
            "d": bad = (y == "x");
            "f": bad = y inside {"k", "q", "v", "x", "z"};
            "g": bad = y inside {"q", "v", "x"};
            "h": bad = y inside {"h", "k", "v", "x", "z"};
            "i": bad = y inside {"y", "i"};
            "j": bad = y inside {"b", "d", "f", "g", "h", "k", "l", "m", "n",
                                 "p", "q", "r", "t", "v", "w", "x", "y", "z"};
            "k": bad = y inside {"g", "q", "v", "x", "z", "p"};
            "l": bad = y inside {"q", "x"};
            "m": bad = y inside {"j", "q", "x", "z"};
            "p": bad = y inside {"q", "v", "x"};
            "q": bad = y inside {"b", "c", "d", "e", "f", "g", "h", "j", "k", "l",
                                 "m", "n", "o", "p", "r", "s", "t", "v", "w", "x",
                                 "y", "z"};
            "u": bad = (y == "u");
            "s": bad = y inside {"x", "z"};
            "t": bad = y inside {"q", "x"};
            "v": bad = y inside {"b", "c", "d", "f", "g", "h", "j", "m", "n", "q",
                                 "t", "w", "x", "z"};
            "w": bad = y inside {"q", "v", "x", "z", "b", "k"};
            "x": bad = y inside {"g", "j", "k", "v", "z", "w", "y"};
            "y": bad = y inside {"d", "j", "q", "v", "z", "w"};
            "z": bad = y inside {"b", "c", "g", "h", "j", "n", "q", "s", "x", "k"};
            default: bad = 1'b0;
        endcase
        return bad;
    endfunction

endpackage

// File: rtl/asbf_dpath.sv
// Datapath: input hold, run state, prefix memory, count and output item register.
module asbf_dpath #(
    parameter int MAX_LEN = asbf_pkg::MAX_MIN_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  asbf_pkg::in_item_t                  byte_data,
    input  logic [asbf_pkg::MIN_LENGTH_W-1:0]   min_length,
    input  asbf_pkg::cmd_t                      cmd,
    output asbf_pkg::status_t                   status,
    output asbf_pkg::out_item_t                 result_data
);

    localparam int RW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    asbf_pkg::in_item_t              in_reg;
    asbf_pkg::out_item_t             out_reg;
    logic                            in_string_reg, in_string_next;
    logic [RW-1:0]                   run_reg, run_next;
    logic [asbf_pkg::BYTE_W-1:0]     prev_reg, prev_next;
    logic [asbf_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]                   k_reg, k_next;
    logic [asbf_pkg::BYTE_W-1:0]     rdata_reg;
    logic [asbf_pkg::BYTE_W-1:0]     prefix_mem [MAX_LEN];

    logic [asbf_pkg::BYTE_W-1:0]     cur_byte;
    logic [RW-1:0]                   thr;
    logic [RW-1:0]                   run_grown;
    logic                            can_store;
    logic [asbf_pkg::COUNT_W-1:0]    count_inc;

    assign cur_byte  = in_reg.byte_in;
    assign can_store = run_reg < RW'(MAX_LEN);
    assign run_grown = can_store ? run_reg + RW'(1) : run_reg;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 32'd1;

    always_comb
    begin
        if (min_length < 6'd2)
        begin
            thr = RW'(2);
        end
        else if (min_length > asbf_pkg::MIN_LENGTH_W'(MAX_LEN))
        begin
            thr = RW'(MAX_LEN);
        end
        else
        begin
            thr = min_length[RW-1:0];
        end
    end

    assign status.in_string   = in_string_reg;
    assign status.alnum       = asbf_pkg::is_alnum(cur_byte);
    assign status.forbid      = asbf_pkg::bigram_bad(prev_reg, cur_byte);
    assign status.run_nonzero = (run_reg != '0);
    assign status.reach_thr   = (run_grown >= thr);
    assign status.last        = in_reg.end_of_buffer;
    assign status.k_final     = ((RW'(k_reg) + RW'(1)) == run_reg);

    always_comb
    begin
        in_string_next = in_string_reg;
        run_next       = run_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        case (cmd.eval_act)
            asbf_pkg::EV_CLEAR_RUN:
            begin
                run_next = '0;
            end
            asbf_pkg::EV_APPEND:
            begin
                run_next  = run_grown;
                prev_next = cur_byte;
            end
            asbf_pkg::EV_EXTEND:
            begin
                prev_next = cur_byte;
            end
            default:
            begin
            end
        endcase
        if (cmd.k_clear)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + AW'(1);
        end
        if (cmd.start_string)
        begin
            in_string_next = 1'b1;
            run_next       = '0;
        end
        if (cmd.end_string)
        begin
            count_next     = count_inc;
            in_string_next = 1'b0;
            run_next       = '0;
        end
        if (cmd.clear_buffer)
        begin
            count_next     = '0;
            in_string_next = 1'b0;
            run_next       = '0;
            prev_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg <= 1'b0;
            run_reg       <= '0;
            prev_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
        end
        else
        begin
            in_string_reg <= in_string_next;
            run_reg       <= run_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= byte_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_act == asbf_pkg::EV_APPEND && can_store)
        begin
            prefix_mem[run_reg[AW-1:0]] <= cur_byte;
        end
        if (cmd.rd_prefix)
        begin
            rdata_reg <= prefix_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.last_of_run <= cmd.out_last;
            case (cmd.out_sel)
                asbf_pkg::OUT_BYTE:
                begin
                    out_reg.kind         <= asbf_pkg::KIND_CHAR;
                    out_reg.char_out     <= cur_byte;
                    out_reg.string_count <= count_reg;
                end
                asbf_pkg::OUT_PREFIX:
                begin
                    out_reg.kind         <= asbf_pkg::KIND_CHAR;
                    out_reg.char_out     <= rdata_reg;
                    out_reg.string_count <= count_reg;
                end
                asbf_pkg::OUT_END:
                begin
                    out_reg.kind         <= asbf_pkg::KIND_END;
                    out_reg.char_out     <= '0;
                    out_reg.string_count <= count_inc;
                end
                default:
                begin
                    out_reg.kind         <= asbf_pkg::KIND_DONE;
                    out_reg.char_out     <= '0;
                    out_reg.string_count <= count_reg;
                end
            endcase
        end
    end

    assign result_data = out_reg;

endmodule

// File: rtl/asbf_ctrl.sv
// Controller: sequences accept, evaluation, prefix replay and result item issue.
module asbf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  asbf_pkg::status_t  status,
    output asbf_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_CHAR   = 3'd2;
    localparam logic [2:0] ST_PRE_RD = 3'd3;
    localparam logic [2:0] ST_PRE_EM = 3'd4;
    localparam logic [2:0] ST_END    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free    = !out_valid_reg || result_ready;
    assign byte_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.in_string)
                begin
                    if (!status.alnum || status.forbid)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        cmd.eval_act = asbf_pkg::EV_EXTEND;
                        state_next   = ST_CHAR;
                    end
                end
                else if (!status.alnum || (status.run_nonzero && status.forbid))
                begin
                    cmd.eval_act = asbf_pkg::EV_CLEAR_RUN;
                    state_next   = status.last ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    cmd.eval_act = asbf_pkg::EV_APPEND;
                    cmd.k_clear  = 1'b1;
                    if (status.reach_thr)
                    begin
                        state_next = ST_PRE_RD;
                    end
                    else
                    begin
                        state_next = status.last ? ST_DONE : ST_IDLE;
                    end
                end
            end
            ST_CHAR:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = asbf_pkg::OUT_BYTE;
                    cmd.out_last = !status.last;
                    state_next   = status.last ? ST_END : ST_IDLE;
                end
            end
            ST_PRE_RD:
            begin
                cmd.rd_prefix = 1'b1;
                state_next    = ST_PRE_EM;
            end
            ST_PRE_EM:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = asbf_pkg::OUT_PREFIX;
                    cmd.out_last = status.k_final && !status.last;
                    if (status.k_final)
                    begin
                        cmd.start_string = 1'b1;
                        state_next       = status.last ? ST_END : ST_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_PRE_RD;
                    end
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = asbf_pkg::OUT_END;
                    cmd.out_last   = !status.last;
                    cmd.end_string = 1'b1;
                    state_next     = status.last ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = asbf_pkg::OUT_DONE;
                    cmd.out_last     = 1'b1;
                    cmd.clear_buffer = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_eval_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_ready) |=> (state_reg == ST_EVAL))
        else $error("accepted item not evaluated next cycle");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result item overwritten before it was taken");

    a_prefix_read_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRE_EM) |->
            ($past(state_reg) == ST_PRE_RD || $past(state_reg) == ST_PRE_EM))
        else $error("prefix issued without a memory read");

    a_done_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_sel == asbf_pkg::OUT_DONE) |->
            (cmd.out_last && cmd.clear_buffer))
        else $error("buffer done item must close the input item");

endmodule

// File: rtl/alnum_string_extractor_bigram_filter_core.sv
// Top level of the bigram-filtered alphanumeric string extractor with its register port.
//
// Input channel byte_valid/byte_ready/byte_data carries one raw byte per item and the
// end_of_buffer flag. Output channel result_valid/result_ready/result_data carries
// result items: string characters, end-of-string markers with the running count, and
// a buffer-done item with the final count. last_of_run marks the last result of a byte.
// min_length is written through the APB port at address 0 (reset value 4).
// An input item that yields no result is only accepted and then evaluated.
// A byte that extends an open string is accepted, evaluated and then issued: its character
// enters the output register from the character state once that register is free.
// Reaching the threshold replays the held prefix from the prefix memory, with one
// registered read and then one issue per character; an end marker or buffer-done item
// is issued from a state of its own. Up to MAX_LEN + 2 results follow one byte.
// The next byte is accepted as soon as the last result of the current one sits in the
// output register, while that item still waits to be taken.
// A stalled receiver holds the output register and the controller waits on it.
// Reset clears the search state, run length, count and output valid; the prefix memory
// is not cleared, since only entries written by the current run are replayed.
module alnum_string_extractor_bigram_filter_core #(
    parameter int MAX_LEN = asbf_pkg::MAX_MIN_LENGTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_ready,
    input  asbf_pkg::in_item_t                byte_data,
    output logic                              result_valid,
    input  logic                              result_ready,
    output asbf_pkg::out_item_t               result_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [asbf_pkg::PADDR_W-1:0]      paddr,
    input  logic [asbf_pkg::DATA_W-1:0]       pwdata,
    output logic [asbf_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [asbf_pkg::MIN_LENGTH_W-1:0] min_length_reg, min_length_next;
    asbf_pkg::cmd_t                    cmd;
    asbf_pkg::status_t                 status;

    assign pready = 1'b1;

    always_comb
    begin
        min_length_next = min_length_reg;
        if (psel && penable && pwrite && paddr == asbf_pkg::ADDR_MIN_LENGTH)
        begin
            min_length_next = pwdata[asbf_pkg::MIN_LENGTH_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == asbf_pkg::ADDR_MIN_LENGTH)
        begin
            prdata = asbf_pkg::DATA_W'(min_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= asbf_pkg::MIN_LENGTH_RESET;
        end
        else
        begin
            min_length_reg <= min_length_next;
        end
    end

    asbf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    asbf_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_data   (byte_data),
        .min_length  (min_length_reg),
        .cmd         (cmd),
        .status      (status),
        .result_data (result_data)
    );

endmodule

// File: tb/alnum_string_extractor_bigram_filter_core_tb.sv
// Self-checking testbench for the bigram-filtered alphanumeric string extractor core.
`timescale 1ns / 1ps

module alnum_string_extractor_bigram_filter_core_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DIR_ROWS      = 26;
    localparam int SEGMENTS      = 4;
    localparam int SEG_ITEMS     = 34;
    localparam int BW            = asbf_pkg::BYTE_W;
    localparam int MW            = asbf_pkg::MIN_LENGTH_W;
    localparam int CW            = asbf_pkg::COUNT_W;
    localparam int HELD_AW       = $clog2(asbf_pkg::MAX_MIN_LENGTH);

    typedef struct packed {
        logic [BW-1:0] byte_val;
        logic          eob;
        logic          cfg_en;
        logic [MW-1:0] cfg_val;
        logic          fixed_done;
        logic [CW-1:0] done_cnt;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, 6'd0,  1'b1, 32'd0},
        '{8'hFF, 1'b1, 1'b0, 6'd0,  1'b1, 32'd0},
        '{"A",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"b",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"1",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"Z",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"q",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"j",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"B",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"0",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"9",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"z",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"a",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{":",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"U",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"u",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"a",   1'b0, 1'b1, 6'd32, 1'b0, 32'd0},
        '{"b",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"c",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"d",   1'b0, 1'b1, 6'd2,  1'b0, 32'd0},
        '{"e",   1'b1, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"H",   1'b0, 1'b1, 6'd0,  1'b0, 32'd0},
        '{"i",   1'b0, 1'b0, 6'd0,  1'b0, 32'd0},
        '{8'h80, 1'b1, 1'b0, 6'd0,  1'b0, 32'd0},
        '{"7",   1'b1, 1'b0, 6'd0,  1'b1, 32'd0}
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              byte_valid = 1'b0;
    logic                              byte_ready;
    asbf_pkg::in_item_t                byte_data = '0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    asbf_pkg::out_item_t               result_data;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [asbf_pkg::PADDR_W-1:0]      paddr = '0;
    logic [asbf_pkg::DATA_W-1:0]       pwdata = '0;
    logic [asbf_pkg::DATA_W-1:0]       prdata;
    logic                              pready;

    string bad_pairs = {"bkbqbx", "cbcfcgcjcpcvcwcx", "dx", "fkfqfvfxfz", "gqgvgx",
                        "hhhkhvhxhz", "iyii", "jbjdjfjgjhjkjljmjnjpjqjrjtjvjwjxjyjz",
                        "kgkqkvkxkzkp", "lqlx", "mjmqmxmz", "pqpvpx",
                        "qbqcqdqeqfqgqhqjqkqlqmqnqoqpqrqsqtqvqwqxqy", "uuqz", "sxsz",
                        "tqtx", "vbvcvdvfvgvhvjvmvnvqvtvwvxvz", "wqwvwxwzwb",
                        "xgxjxkxvxzxwxywk", "ydyjyqyvyzyw", "zbzczgzhzjznzqzszxzk"};
    string common_letters = "etaoinsrhldcumgpybw";

    logic [MW-1:0] cfg_min_len = asbf_pkg::MIN_LENGTH_RESET;
    logic          in_str = 1'b0;
    logic [MW-1:0] run_len = '0;
    logic [BW-1:0] prev_char = '0;
    logic [BW-1:0] held_chars [asbf_pkg::MAX_MIN_LENGTH];
    logic [CW-1:0] found_cnt = '0;

    asbf_pkg::out_item_t expected_results [$];
    asbf_pkg::out_item_t byte_results [$];
    asbf_pkg::out_item_t want_item;

    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int word_left = 0;

    alnum_string_extractor_bigram_filter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic is_word_char(input logic [BW-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [BW-1:0] lower_case(input logic [BW-1:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic pair_blocked(input logic [BW-1:0] a,
                                          input logic [BW-1:0] b);
        int i;
        logic [BW-1:0] x;
        logic [BW-1:0] y;
        x = lower_case(a);
        y = lower_case(b);
        for (i = 0; i + 1 < bad_pairs.len(); i += 2)
        begin
            if (bad_pairs[i] == x && bad_pairs[i + 1] == y)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit(input logic [asbf_pkg::KIND_W-1:0] k,
                                 input logic [BW-1:0] ch);
        byte_results.push_back('{kind: k, char_out: ch, string_count: found_cnt,
                                 last_of_run: 1'b0});
    endfunction

    function automatic void count_string();
        if (found_cnt != '1)
            found_cnt = found_cnt + 1'b1;
    endfunction

    // Advance the scanner by one byte and collect the results it causes.
    function automatic void scan_byte(input asbf_pkg::in_item_t it);
        logic [BW-1:0]       c;
        logic [MW-1:0]       thr;
        asbf_pkg::out_item_t tail;
        int                  k;
        c = it.byte_in;
        thr = (cfg_min_len < 2) ? 6'd2 :
              (cfg_min_len > asbf_pkg::MAX_MIN_LENGTH) ? 6'(asbf_pkg::MAX_MIN_LENGTH) :
              cfg_min_len;
        byte_results.delete();
        if (in_str)
        begin
            if (!is_word_char(c) || pair_blocked(prev_char, c))
            begin
                count_string();
                emit(asbf_pkg::KIND_END, 8'h00);
                in_str = 1'b0;
                run_len = '0;
            end
            else
            begin
                emit(asbf_pkg::KIND_CHAR, c);
                prev_char = c;
            end
        end
        else if (!is_word_char(c))
            run_len = '0;
        else if (run_len != 0 && pair_blocked(prev_char, c))
            run_len = '0;
        else
        begin
            if (run_len < asbf_pkg::MAX_MIN_LENGTH)
            begin
                held_chars[run_len[HELD_AW-1:0]] = c;
                run_len = run_len + 1'b1;
            end
            prev_char = c;
            if (run_len >= thr)
            begin
                for (k = 0; k < run_len; k++)
                    emit(asbf_pkg::KIND_CHAR, held_chars[HELD_AW'(k)]);
                in_str = 1'b1;
                run_len = '0;
            end
        end
        if (it.end_of_buffer)
        begin
            if (in_str)
            begin
                count_string();
                emit(asbf_pkg::KIND_END, 8'h00);
            end
            emit(asbf_pkg::KIND_DONE, 8'h00);
            found_cnt = '0;
            in_str = 1'b0;
            run_len = '0;
            prev_char = '0;
        end
        if (byte_results.size() > 0)
        begin
            tail = byte_results.pop_back();
            tail.last_of_run = 1'b1;
            byte_results.push_back(tail);
        end
    endfunction

    function automatic logic [BW-1:0] random_word_char();
        logic [BW-1:0] c;
        int            r;
        if ($urandom_range(99) < 75)
        begin
            c = common_letters[$urandom_range(common_letters.len() - 1)];
            if ($urandom_range(3) == 0)
                c = c - 8'd32;
        end
        else
        begin
            r = $urandom_range(61);
            if (r < 10)
                c = 8'("0" + r);
            else if (r < 36)
                c = 8'("A" + r - 10);
            else
                c = 8'("a" + r - 36);
        end
        return c;
    endfunction

    function automatic asbf_pkg::in_item_t next_random_item();
        asbf_pkg::in_item_t it;
        if (word_left == 0 && $urandom_range(99) < 60)
        begin
            it.byte_in = 8'($urandom_range(255));
            it.end_of_buffer = ($urandom_range(15) == 0);
            return it;
        end
        if (word_left == 0)
            word_left = ($urandom_range(99) < 80) ? $urandom_range(1, 8) :
                                                    $urandom_range(9, 36);
        word_left--;
        it.byte_in = random_word_char();
        it.end_of_buffer = (word_left == 0) && ($urandom_range(9) == 0);
        return it;
    endfunction

    function automatic logic [MW-1:0] pick_min_length(input int phase, input int seg);
        if (seg == 0)
            return (phase == 0) ? 6'd0 : (phase == 1) ? 6'd32 : 6'd1;
        if ($urandom_range(5) == 0)
            return 6'($urandom_range(asbf_pkg::MAX_MIN_LENGTH));
        return 6'($urandom_range(2, 10));
    endfunction

    function automatic void check_field(input string name, input logic [CW-1:0] want,
                                        input logic [CW-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_item(input asbf_pkg::in_item_t it, input logic fixed_done,
                             input logic [CW-1:0] done_cnt);
        int i;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= it;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        scan_byte(it);
        if (fixed_done)
            expected_results.push_back('{kind: asbf_pkg::KIND_DONE, char_out: 8'h00,
                                         string_count: done_cnt, last_of_run: 1'b1});
        else
            for (i = 0; i < byte_results.size(); i++)
                expected_results.push_back(byte_results[i]);
    endtask

    // Hold the input low until every expected result is out and the core has settled.
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_length(input logic [MW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= asbf_pkg::ADDR_MIN_LENGTH;
        pwdata <= asbf_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_min_len = value;
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, expected none, got %0h", $time, result_data);
            end
            else
            begin
                want_item = expected_results.pop_front();
                check_field("kind", CW'(want_item.kind), CW'(result_data.kind));
                check_field("char_out", CW'(want_item.char_out),
                            CW'(result_data.char_out));
                check_field("string_count", want_item.string_count, result_data.string_count);
                check_field("last_of_run", CW'(want_item.last_of_run),
                            CW'(result_data.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("alnum_string_extractor_bigram_filter_core_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int                 row;
        int                 phase;
        int                 seg;
        int                 n;
        asbf_pkg::in_item_t item;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 55;
        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (DIRECTED[row].cfg_en)
            begin
                wait_idle();
                write_min_length(DIRECTED[row].cfg_val);
            end
            item = '{byte_in: DIRECTED[row].byte_val, end_of_buffer: DIRECTED[row].eob};
            send_item(item, DIRECTED[row].fixed_done, DIRECTED[row].done_cnt);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 26 : 0;
            for (seg = 0; seg < SEGMENTS; seg++)
            begin
                wait_idle();
                write_min_length(pick_min_length(phase, seg));
                if (phase == 2 && seg == 0)
                    hold_req++;
                for (n = 0; n < SEG_ITEMS; n++)
                begin
                    item = next_random_item();
                    send_item(item, 1'b0, '0);
                end
            end
        end

        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("alnum_string_extractor_bigram_filter_core_tb: clean");
        else
            $display("alnum_string_extractor_bigram_filter_core_tb: errors");
        $finish;
    end

endmodule
